// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// ===== rtl/core/tlpn_pkg.sv =====
// types, constants and lfsr step functions for the complex pn generator
`default_nettype none

package tlpn_pkg;

  localparam int A_W        = 11;
  localparam int B_W        = 11;
  localparam int C_W        = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_SEED_A = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_C = CFG_IDX_W'(1);

  localparam logic [A_W-1:0] SEED_A_RST  = A_W'(1);
  localparam logic [C_W-1:0] SEED_C_RST  = C_W'(1);
  localparam logic [B_W-1:0] B_INIT      = B_W'(1);
  localparam logic [C_W-1:0] ZERO_Q_SEED = 12'o7777;

  localparam int TAP_LO = 0;
  localparam int TAP_HI = 9;
  localparam int TAP_B1 = 3;
  localparam int TAP_B2 = 6;

  typedef struct packed {
    logic chip_i;
    logic chip_q;
    logic last_chip;
  } chip_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  function automatic logic [A_W-1:0] step_a(input logic [A_W-1:0] v);
    return {v[TAP_LO] ^ v[TAP_HI], v[A_W-1:1]};
  endfunction

  function automatic logic [B_W-1:0] step_b(input logic [B_W-1:0] v);
    return {v[TAP_LO] ^ v[TAP_B1] ^ v[TAP_B2] ^ v[TAP_HI], v[B_W-1:1]};
  endfunction

  // bit 11 drops into bit 10 on the shift and is or'ed with the feedback
  function automatic logic [C_W-1:0] step_c(input logic [C_W-1:0] v);
    return {1'b0, v[C_W-1] | (v[TAP_LO] ^ v[TAP_HI]), v[C_W-2:1]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tlpn_if.sv =====
// handshake interfaces for the input, result and config channels
`default_nettype none

interface tlpn_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface tlpn_out_if;
  logic valid;
  logic ready;
  logic chip_i;
  logic chip_q;
  logic last_chip;
  modport source (output valid, output chip_i, output chip_q, output last_chip, input ready);
  modport sink   (input valid, input chip_i, input chip_q, input last_chip, output ready);
endinterface

interface tlpn_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tlpn_pkg::CFG_IDX_W-1:0]  index;
  logic [tlpn_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/three_lfsr_complex_pn_generator.sv =====
// top level of the three-lfsr complex pn chip generator
// usage:
//   in_if   : one word per chip tick; restart = 1 reloads the seeds and the
//             chip counter before that chip is produced
//   out_if  : one word per accepted input word, carrying chip_i, chip_q and
//             last_chip (set on the final chip of each sequence)
//   cfg_if  : index 0 writes seed_a, index 1 writes seed_c; other indexes
//             are ignored; always ready; seeds take effect at the next reload
// result: registered, shown on out_if in the cycle after its input word is taken
// throughput: one chip per clock while out_if.ready is high, set by the single result register
// reset: seeds are 1, lfsr a/b/c are 1, chip counter is 0, q zeroing is off
// stall: while a result waits and out_if.ready is low, in_if.ready drops;
//   the result register holds its word until it is taken
// a sequence is SEQUENCE_LENGTH chips long and then repeats on its own
`default_nettype none

module three_lfsr_complex_pn_generator #(
  parameter int SEQUENCE_LENGTH = 2047
) (
  input logic         clk,
  input logic         rst_n,
  tlpn_in_if.sink     in_if,
  tlpn_out_if.source  out_if,
  tlpn_cfg_if.sink    cfg_if
);

  tlpn_pkg::cfg_wr_t cfg;
  tlpn_pkg::chip_t   chip;
  tlpn_pkg::chip_t   chip_r;
  logic              step;
  logic              in_ready;

  assign cfg_if.ready = 1'b1;
  assign cfg.we       = cfg_if.valid;
  assign cfg.idx      = cfg_if.index;
  assign cfg.data     = cfg_if.data;

  assign in_if.ready  = in_ready;
  assign step         = in_if.valid && in_ready;

  tlpn_core #(
    .SEQUENCE_LENGTH(SEQUENCE_LENGTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .step    (step),
    .restart (in_if.restart),
    .chip    (chip)
  );

  tlpn_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .din       (chip),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .dout      (chip_r),
    .in_ready  (in_ready)
  );

  assign out_if.chip_i    = chip_r.chip_i;
  assign out_if.chip_q    = chip_r.chip_q;
  assign out_if.last_chip = chip_r.last_chip;

endmodule

`default_nettype wire

// ===== rtl/core/tlpn_core.sv =====
// seed registers, lfsr state and per-chip step logic
`default_nettype none

module tlpn_core #(
  parameter int SEQUENCE_LENGTH = 2047
) (
  input  logic            clk,
  input  logic            rst_n,
  input  tlpn_pkg::cfg_wr_t cfg,
  input  logic            step,
  input  logic            restart,
  output tlpn_pkg::chip_t chip
);

  localparam int IDX_W = (SEQUENCE_LENGTH > 1) ? $clog2(SEQUENCE_LENGTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SEQUENCE_LENGTH - 1);

  logic [tlpn_pkg::A_W-1:0] seed_a_r;
  logic [tlpn_pkg::C_W-1:0] seed_c_r;
  logic [tlpn_pkg::A_W-1:0] lfsr_a_r, lfsr_a_nxt, a_cur;
  logic [tlpn_pkg::B_W-1:0] lfsr_b_r, lfsr_b_nxt, b_cur;
  logic [tlpn_pkg::C_W-1:0] lfsr_c_r, lfsr_c_nxt, c_cur;
  logic [IDX_W-1:0]         idx_r, idx_nxt, idx_cur;
  logic                     zq_r, zq_nxt, zq_cur, zq_seed, last;

  always_comb begin
    zq_seed = (seed_c_r == tlpn_pkg::ZERO_Q_SEED);
    // restart reloads before this chip
    a_cur   = restart ? seed_a_r : lfsr_a_r;
    b_cur   = restart ? tlpn_pkg::B_INIT : lfsr_b_r;
    c_cur   = restart ? seed_c_r : lfsr_c_r;
    idx_cur = restart ? '0 : idx_r;
    zq_cur  = restart ? zq_seed : zq_r;
    last    = (idx_cur >= LAST_IDX);

    chip.chip_i    = a_cur[0] ^ b_cur[0];
    chip.chip_q    = zq_cur ? 1'b0 : (c_cur[0] ^ b_cur[0]);
    chip.last_chip = last;

    if (last) begin
      lfsr_a_nxt = seed_a_r;
      lfsr_b_nxt = tlpn_pkg::B_INIT;
      lfsr_c_nxt = seed_c_r;
      idx_nxt    = '0;
      zq_nxt     = zq_seed;
    end else begin
      lfsr_a_nxt = tlpn_pkg::step_a(a_cur);
      lfsr_b_nxt = tlpn_pkg::step_b(b_cur);
      lfsr_c_nxt = tlpn_pkg::step_c(c_cur);
      idx_nxt    = idx_cur + IDX_W'(1);
      zq_nxt     = zq_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_a_r <= tlpn_pkg::SEED_A_RST;
      seed_c_r <= tlpn_pkg::SEED_C_RST;
      lfsr_a_r <= tlpn_pkg::SEED_A_RST;
      lfsr_b_r <= tlpn_pkg::B_INIT;
      lfsr_c_r <= tlpn_pkg::SEED_C_RST;
      idx_r    <= '0;
      zq_r     <= 1'b0;
    end else begin
      if (cfg.we) begin
        case (cfg.idx)
          tlpn_pkg::CFG_SEED_A: seed_a_r <= cfg.data[tlpn_pkg::A_W-1:0];
          tlpn_pkg::CFG_SEED_C: seed_c_r <= cfg.data[tlpn_pkg::C_W-1:0];
          default: ;
        endcase
      end
      if (step) begin
        lfsr_a_r <= lfsr_a_nxt;
        lfsr_b_r <= lfsr_b_nxt;
        lfsr_c_r <= lfsr_c_nxt;
        idx_r    <= idx_nxt;
        zq_r     <= zq_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tlpn_out_reg.sv =====
// result register with valid/ready toward the receiver
`default_nettype none

module tlpn_out_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  tlpn_pkg::chip_t din,
  input  logic            out_ready,
  output logic            out_valid,
  output tlpn_pkg::chip_t dout,
  output logic            in_ready
);

  logic            valid_r;
  tlpn_pkg::chip_t data_r;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign dout      = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= din;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tlpn_checker.sv =====
// port-level checks for the complex pn generator, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module tlpn_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic chip_i,
  input logic chip_q,
  input logic last_chip
);

  // an accepted word always yields a result word next cycle
  `ASSERT_NEXT(a_accept_gives_result, clk, rst_n, in_valid && in_ready, out_valid)

  // an empty result register never blocks the input
  `ASSERT_IMPLIES(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)

  // a stalled result blocks the input
  `ASSERT_IMPLIES(a_block_on_stall, clk, rst_n, out_valid && !out_ready, !in_ready)

  // a stalled result word holds
  `ASSERT_NEXT(a_hold_on_stall, clk, rst_n, out_valid && !out_ready, out_valid && $stable(chip_i) && $stable(chip_q) && $stable(last_chip))

endmodule

bind three_lfsr_complex_pn_generator tlpn_checker u_tlpn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .chip_i    (out_if.chip_i),
  .chip_q    (out_if.chip_q),
  .last_chip (out_if.last_chip)
);

`default_nettype wire

// ===== tb/sv/tb_three_lfsr_complex_pn_generator.sv =====
// self-checking testbench for the three-lfsr complex pn chip generator
module tb_three_lfsr_complex_pn_generator;
  import tlpn_pkg::*;

  localparam int SEQ_LEN        = 2047;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);

  logic clk;
  logic rst_n;

  tlpn_in_if  in_ch ();
  tlpn_out_if out_ch ();
  tlpn_cfg_if cfg_ch ();

  three_lfsr_complex_pn_generator #(
    .SEQUENCE_LENGTH(SEQ_LEN)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  logic  restart_words[$];
  chip_t expected_chips[$];

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  bit hold_enable    = 1'b0;
  int hold_count;
  int planned_idx    = 0;
  int mismatch_count = 0;
  int quiet_cycles;

  logic [A_W-1:0] seed_a_shadow;
  logic [C_W-1:0] seed_c_shadow;
  logic [A_W-1:0] pn_a;
  logic [B_W-1:0] pn_b;
  logic [C_W-1:0] pn_c;
  logic [10:0]    chip_count;
  logic           q_zeroed;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function void reload_lfsrs();
    pn_a       = seed_a_shadow;
    pn_b       = B_INIT;
    pn_c       = seed_c_shadow;
    chip_count = '0;
    q_zeroed   = (seed_c_shadow == ZERO_Q_SEED);
  endfunction

  function chip_t predict_chip(input logic restart);
    chip_t          c;
    logic           fa;
    logic           fb;
    logic           fc;
    logic [C_W-1:0] next_c;
    if (restart) reload_lfsrs();
    c.chip_i    = pn_a[0] ^ pn_b[0];
    c.chip_q    = q_zeroed ? 1'b0 : (pn_c[0] ^ pn_b[0]);
    c.last_chip = (chip_count >= SEQ_LEN - 1);
    fa = pn_a[0] ^ pn_a[9];
    fb = pn_b[0] ^ pn_b[3] ^ pn_b[6] ^ pn_b[9];
    fc = pn_c[0] ^ pn_c[9];
    pn_a = {fa, pn_a[A_W-1:1]};
    pn_b = {fb, pn_b[B_W-1:1]};
    next_c = pn_c >> 1;
    next_c[10] = next_c[10] | fc;
    pn_c = next_c;
    if (c.last_chip) reload_lfsrs();
    else chip_count = chip_count + 1'b1;
    return c;
  endfunction

  task automatic report_mismatch(input string what, input logic want, input logic got);
    $display("mismatch at %0t: %s expected %b got %b", $time, what, want, got);
    mismatch_count++;
  endtask

  // word source
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.restart <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (restart_words.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        in_ch.valid   <= 1'b1;
        in_ch.restart <= restart_words.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result sink, with one long hold-off once enabled
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_count   <= 0;
    end else if (hold_enable && hold_count < HOLD_CYCLES) begin
      out_ch.ready <= 1'b0;
      hold_count   <= hold_count + 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    chip_t want;
    if (!rst_n) begin
      seed_a_shadow = SEED_A_RST;
      seed_c_shadow = SEED_C_RST;
      pn_a          = SEED_A_RST;
      pn_b          = B_INIT;
      pn_c          = SEED_C_RST;
      chip_count    = '0;
      q_zeroed      = 1'b0;
      expected_chips.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_SEED_A: seed_a_shadow = cfg_ch.data[A_W-1:0];
          CFG_SEED_C: seed_c_shadow = cfg_ch.data[C_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        expected_chips.push_back(predict_chip(in_ch.restart));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_chips.size() == 0) begin
          report_mismatch("word with nothing expected", 1'b0, 1'b1);
        end else begin
          want = expected_chips.pop_front();
          if (out_ch.chip_i !== want.chip_i)
            report_mismatch("chip_i", want.chip_i, out_ch.chip_i);
          if (out_ch.chip_q !== want.chip_q)
            report_mismatch("chip_q", want.chip_q, out_ch.chip_q);
          if (out_ch.last_chip !== want.last_chip)
            report_mismatch("last_chip", want.last_chip, out_ch.last_chip);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_three_lfsr_complex_pn_generator: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_word(input logic restart);
    restart_words.push_back(restart);
    if (restart) planned_idx = 0;
    if (planned_idx == SEQ_LEN - 1) planned_idx = 0;
    else planned_idx++;
  endtask

  task automatic queue_to_last(input logic restart);
    while (planned_idx != SEQ_LEN - 1) queue_word(1'b0);
    queue_word(restart);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (restart_words.size() != 0 || in_ch.valid || expected_chips.size() != 0);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic randomize_seeds();
    logic [CFG_DATA_W-1:0] seed_c_val;
    case ($urandom_range(5))
      0: seed_c_val = ZERO_Q_SEED;
      1: seed_c_val = '0;
      default: seed_c_val = CFG_DATA_W'($urandom_range(4095));
    endcase
    write_cfg(CFG_SEED_A, CFG_DATA_W'($urandom_range(4095)));
    write_cfg(CFG_SEED_C, seed_c_val);
    if ($urandom_range(1) == 0)
      write_cfg($urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3,
                CFG_DATA_W'($urandom_range(4095)));
  endtask

  task automatic random_phase(input int src_pct, input int sink_pct, input int n);
    randomize_seeds();
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    repeat (n) queue_word($urandom_range(31) == 0);
    wait_idle();
  endtask

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.restart = 1'b0;
    out_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = CFG_SEED_A;
    cfg_ch.data   = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    repeat (3) queue_word(1'b0);
    wait_idle();

    // new seeds only show after the next reload
    write_cfg(CFG_SEED_A, '1);
    write_cfg(CFG_SEED_C, ZERO_Q_SEED);
    repeat (2) queue_word(1'b0);
    queue_word(1'b1);
    repeat (3) queue_word(1'b0);
    wait_idle();

    // all-zero seeds, unused indexes ignored
    write_cfg(CFG_SEED_A, '0);
    write_cfg(CFG_SEED_C, '0);
    write_cfg(CFG_SPARE_2, '1);
    write_cfg(CFG_SPARE_3, CFG_DATA_W'(12'hABC));
    queue_word(1'b1);
    repeat (3) queue_word(1'b0);
    wait_idle();

    // tap bit of a alone, bit 11 of c alone
    write_cfg(CFG_SEED_A, CFG_DATA_W'(11'h200));
    write_cfg(CFG_SEED_C, CFG_DATA_W'(12'h800));
    repeat (2) queue_word(1'b1);
    repeat (3) queue_word(1'b0);
    wait_idle();

    random_phase(0, 0, 50);
    random_phase(79, 0, 50);
    random_phase(0, 79, 50);
    random_phase(21, 21, 50);

    // run on to the natural wrap of the sequence and past it, under a long sink hold
    randomize_seeds();
    src_idle_pct   = 21;
    sink_stall_pct = 21;
    hold_enable    = 1'b1;
    queue_to_last(1'b0);
    repeat (8) queue_word(1'b0);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_three_lfsr_complex_pn_generator: done, clean");
    end else begin
      $display("tb_three_lfsr_complex_pn_generator: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/tlpn_pkg.sv
rtl/core/tlpn_if.sv
rtl/core/tlpn_core.sv
rtl/core/tlpn_out_reg.sv
rtl/core/three_lfsr_complex_pn_generator.sv
rtl/core/tlpn_checker.sv
tb/sv/tb_three_lfsr_complex_pn_generator.sv
